/* rtl/core/bsd_pkg.sv */
// Shared types, constants and the alphabet lookup for the base64 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package bsd_pkg;

  // Width of the per-message byte counter.
  localparam int unsigned CountBits  = 24;
  // Width of the output byte limit register.
  localparam int unsigned LimitWidth = 24;
  // Width used when comparing the counter against the limit.
  localparam int unsigned CmpWidth   = (CountBits > LimitWidth) ? CountBits : LimitWidth;

  // Group records held between the front and the back end.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Character codes of the alphabet boundaries.
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharDigit0 = 8'h30;
  localparam logic [7:0] CharDigit9 = 8'h39;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharSlash  = 8'h2F;

  // One closed group: up to three decoded bytes, first byte in entry 0.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            eom;
  } bsd_grp_t;

  // Sextet lookup result.
  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } bsd_sextet_t;

  // Maps a character onto its 6-bit value; valid is low outside the alphabet.
  function automatic bsd_sextet_t sextet_of(input logic [7:0] c);
    bsd_sextet_t r;
    r = '0;
    case (c) inside
      [CharUpperA:CharUpperZ]: r = '{valid: 1'b1, value: 6'(c - CharUpperA)};
      [CharLowerA:CharLowerZ]: r = '{valid: 1'b1, value: 6'(c - CharLowerA + 8'd26)};
      [CharDigit0:CharDigit9]: r = '{valid: 1'b1, value: 6'(c - CharDigit0 + 8'd52)};
      CharPlus:                r = '{valid: 1'b1, value: 6'd62};
      CharSlash:               r = '{valid: 1'b1, value: 6'd63};
      default:                 r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bsd_front.sv */
// Front end: accepts characters, gathers sextets and closes groups into records.
`timescale 1ns / 1ps
`default_nettype none

module bsd_front
  import bsd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [7:0]            char_code_i,
  input  wire logic                  last_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic [LimitWidth-1:0] cfg_data_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output bsd_grp_t                   q_data_o
);

  logic [1:0]            pos_q, pos_d;
  logic [2:0]            sc_q, sc_d;
  logic [23:0]           acc_q, acc_d;
  logic [CountBits-1:0]  be_q, be_d;
  logic [LimitWidth-1:0] limit_q;

  bsd_sextet_t           sx;
  logic                  take;
  logic                  accept;
  logic                  close;
  logic [2:0]            n_upd;
  logic [23:0]           acc_upd;
  logic [23:0]           just;
  logic [1:0]            nb;
  logic [1:0]            m;
  logic [CmpWidth-1:0]   limit_x;
  logic [CmpWidth-1:0]   be_x;
  logic [CmpWidth-1:0]   avail;
  logic [CountBits:0]    be_sum;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Sextet lookup and accumulator update for the incoming character.
  always_comb begin
    sx      = sextet_of(char_code_i);
    take    = sx.valid && (sc_q < 3'd4);
    n_upd   = take ? sc_q + 3'd1 : sc_q;
    acc_upd = take ? {acc_q[17:0], sx.value} : acc_q;
    close   = (pos_q == 2'd3) || last_i;
  end

  // Left-justify the gathered sextets and count the bytes they hold.
  always_comb begin
    case (n_upd)
      3'd4:    just = acc_upd;
      3'd3:    just = {acc_upd[17:0], 6'd0};
      3'd2:    just = {acc_upd[11:0], 12'd0};
      default: just = {acc_upd[5:0], 18'd0};
    endcase
    nb = (n_upd >= 3'd2) ? 2'(n_upd - 3'd1) : 2'd0;
  end

  // Apply the output byte limit to this group.
  always_comb begin
    limit_x = CmpWidth'(limit_q);
    be_x    = CmpWidth'(be_q);
    avail   = (limit_x > be_x) ? limit_x - be_x : '0;
    if (limit_q == '0) begin
      m = nb;
    end else if (avail < CmpWidth'(nb)) begin
      m = avail[1:0];
    end else begin
      m = nb;
    end
    be_sum = {1'b0, be_q} + (CountBits+1)'(m);
  end

  // Record toward the back end.
  always_comb begin
    q_push_o       = accept && close && ((m != 2'd0) || last_i);
    q_data_o.bytes = {just[7:0], just[15:8], just[23:16]};
    q_data_o.cnt   = m;
    q_data_o.eom   = last_i;
  end

  // Next group and message state.
  always_comb begin
    pos_d = pos_q;
    sc_d  = sc_q;
    acc_d = acc_q;
    be_d  = be_q;
    if (accept) begin
      if (close) begin
        pos_d = 2'd0;
        sc_d  = 3'd0;
        acc_d = '0;
      end else begin
        pos_d = pos_q + 2'd1;
        sc_d  = n_upd;
        acc_d = acc_upd;
      end
      if (last_i) begin
        be_d = '0;
      end else if (close) begin
        be_d = be_sum[CountBits] ? {CountBits{1'b1}} : be_sum[CountBits-1:0];
      end
    end
  end

  // State registers and the limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sc_q    <= '0;
      acc_q   <= '0;
      be_q    <= '0;
      limit_q <= '0;
    end else begin
      pos_q <= pos_d;
      sc_q  <= sc_d;
      acc_q <= acc_d;
      be_q  <= be_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bsd_queue.sv */
// Short queue of group records between the front and the back end.
`timescale 1ns / 1ps
`default_nettype none

module bsd_queue
  import bsd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire bsd_grp_t  push_data_i,
  input  wire logic      pop_i,
  output bsd_grp_t       head_o,
  output logic           not_empty_o,
  output logic           full_o
);

  bsd_grp_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]   cnt_q;
  logic                   do_push;
  logic                   do_pop;

  assign full_o      = (cnt_q == QueueCntW'(QueueDepth));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Record storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bsd_back.sv */
// Back end: walks each group record and sends its bytes through an output register.
`timescale 1ns / 1ps
`default_nettype none

module bsd_back
  import bsd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire bsd_grp_t head_i,
  input  wire logic     head_valid_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output logic [7:0]    data_byte_o,
  output logic          byte_valid_o,
  output logic          end_of_message_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] data_q;
  logic       bv_q;
  logic       eom_q;

  logic       load;
  logic       rec_done;
  logic       marker;

  // Pick the next request out of the head record.
  always_comb begin
    marker   = (head_i.cnt == 2'd0);
    rec_done = marker || (idx_q == head_i.cnt - 2'd1);
    load     = head_valid_i && (!out_valid_q || out_ready_i);
    pop_o    = load && rec_done;
    idx_d    = idx_q;
    if (load) begin
      idx_d = rec_done ? 2'd0 : idx_q + 2'd1;
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= marker ? 8'd0 : head_i.bytes[idx_q];
      bv_q   <= !marker;
      eom_q  <= head_i.eom && rec_done;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_byte_o      = data_q;
  assign byte_valid_o     = bv_q;
  assign end_of_message_o = eom_q;

endmodule

`default_nettype wire

/* rtl/core/base64_stream_decoder_unit.sv */
// Top level of the base64 stream decoder: front end, record queue and back end.
// Takes one character per cycle while the record queue has room.
// A closed group's bytes pass the record queue and then the output register.
// The output register sends one byte per cycle while the receiver is ready.
// Reset clears group state, byte count, limit, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_decoder_unit
  import bsd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [7:0]            char_code_i,
  input  wire logic                  last_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [7:0]                 data_byte_o,
  output logic                       byte_valid_o,
  output logic                       end_of_message_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [LimitWidth-1:0] cfg_data_i
);

  bsd_grp_t push_data;
  bsd_grp_t head;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_not_empty;

  // The limit register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  bsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .last_i      (last_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (push),
    .q_data_o    (push_data)
  );

  bsd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (q_not_empty),
    .full_o      (q_full)
  );

  bsd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .head_valid_i     (q_not_empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .data_byte_o      (data_byte_o),
    .byte_valid_o     (byte_valid_o),
    .end_of_message_o (end_of_message_o)
  );

endmodule

`default_nettype wire

/* rtl/core/bsd_checker.sv */
// Port-level checks for the base64 stream decoder and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bsd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] data_byte_o,
  input wire logic       byte_valid_o,
  input wire logic       end_of_message_o
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o)
      && $stable(byte_valid_o) && $stable(end_of_message_o))
    else $error("stalled result changed");

  // A result without a byte is a bare end marker with a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> end_of_message_o && (data_byte_o == 8'd0))
    else $error("empty result is not an end marker");

  // A full queue always has a result waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled while output is empty");

  // Once reset has been seen at an edge, no result is shown at the next one.
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind base64_stream_decoder_unit bsd_checker u_bsd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .data_byte_o      (data_byte_o),
  .byte_valid_o     (byte_valid_o),
  .end_of_message_o (end_of_message_o)
);

`default_nettype wire

/* bench/base64_decode_checker.sv */
// Checker for the base64 stream decoder: predicts decoded bytes and compares them.
`timescale 1ns / 1ps

module base64_decode_checker
  import bsd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_o,
  input  wire logic [7:0]            char_code_i,
  input  wire logic                  last_i,
  input  wire logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire logic [7:0]            data_byte_o,
  input  wire logic                  byte_valid_o,
  input  wire logic                  end_of_message_o,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_o,
  input  wire logic [LimitWidth-1:0] cfg_data_i,
  output int                         fail_count_o,
  output int                         awaited_o
);

  // One decoded result as the block should present it.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } decoded_t;

  decoded_t awaited_bytes[$];

  // Shadow copy of the decoder state and its limit register.
  logic [1:0]            grp_pos;
  logic [2:0]            sext_cnt;
  logic [23:0]           acc;
  logic [CountBits-1:0]  emitted;
  logic [LimitWidth-1:0] byte_limit;
  int                    errors;

  // Returns the 6-bit value of a character in bits 5:0; bit 6 is set inside the alphabet.
  function automatic logic [6:0] sextet_value(input logic [7:0] c);
    logic [6:0] v;
    v = '0;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      v = {1'b1, 6'(c - CharUpperA)};
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      v = {1'b1, 6'(c - CharLowerA + 8'd26)};
    end else if (c >= CharDigit0 && c <= CharDigit9) begin
      v = {1'b1, 6'(c - CharDigit0 + 8'd52)};
    end else if (c == CharPlus) begin
      v = {1'b1, 6'd62};
    end else if (c == CharSlash) begin
      v = {1'b1, 6'd63};
    end
    return v;
  endfunction

  // Advances the shadow state by one character and queues the bytes it releases.
  task automatic decode_char(input logic [7:0] c, input logic fin);
    logic [6:0]  sx;
    logic [23:0] aligned;
    decoded_t    batch[3];
    int          produced;
    int          shift;
    int          k;
    sx = sextet_value(c);
    produced = 0;
    if (sx[6] && sext_cnt < 3'd4) begin
      acc = {acc[17:0], sx[5:0]};
      sext_cnt = sext_cnt + 3'd1;
    end
    // A group closes on its fourth position or on the final character.
    if (grp_pos == 2'd3 || fin) begin
      if (sext_cnt >= 3'd2) begin
        shift = 6 * (4 - int'(sext_cnt));
        aligned = acc << shift;
        for (k = 0; k < int'(sext_cnt) - 1; k++) begin
          if (byte_limit == '0 || emitted < byte_limit) begin
            batch[produced] = '{data: aligned[23 - 8 * k -: 8], has_byte: 1'b1, eom: 1'b0};
            produced++;
            if (emitted != '1) emitted = emitted + 1'b1;
          end
        end
      end
      grp_pos = '0;
      sext_cnt = '0;
      acc = '0;
    end else begin
      grp_pos = grp_pos + 2'd1;
    end
    // The final character always ends with a marked result, a bare one if needed.
    if (fin) begin
      if (produced == 0) begin
        batch[0] = '{data: 8'h00, has_byte: 1'b0, eom: 1'b1};
        produced = 1;
      end else begin
        batch[produced - 1].eom = 1'b1;
      end
      emitted = '0;
    end
    for (k = 0; k < produced; k++) awaited_bytes = {awaited_bytes, batch[k]};
  endtask

  // Watch all three channels at each edge.
  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t seen;
    decoded_t want;
    if (!rst_ni) begin
      grp_pos = '0;
      sext_cnt = '0;
      acc = '0;
      emitted = '0;
      byte_limit = '0;
      errors = 0;
      awaited_bytes.delete();
      fail_count_o <= 0;
      awaited_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) byte_limit = cfg_data_i;
      if (out_valid_o && out_ready_i) begin
        seen = '{data: data_byte_o, has_byte: byte_valid_o, eom: end_of_message_o};
        if (awaited_bytes.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %02h/%b/%b",
                   $time, seen.data, seen.has_byte, seen.eom);
          errors++;
        end else begin
          want = awaited_bytes.pop_front();
          if (seen.data != want.data) begin
            $display("%0t ns: data_byte expected %02h, actual %02h",
                     $time, want.data, seen.data);
            errors++;
          end
          if (seen.has_byte != want.has_byte) begin
            $display("%0t ns: byte_valid expected %b, actual %b",
                     $time, want.has_byte, seen.has_byte);
            errors++;
          end
          if (seen.eom != want.eom) begin
            $display("%0t ns: end_of_message expected %b, actual %b",
                     $time, want.eom, seen.eom);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_o) decode_char(char_code_i, last_i);
      fail_count_o <= errors;
      awaited_o <= awaited_bytes.size();
    end
  end

endmodule

/* bench/testbench.sv */
// Stimulus, clocking and verdict for the base64 stream decoder bench.
`timescale 1ns / 1ps

module testbench;
  import bsd_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 16;
  localparam int PhaseItems    = 47;

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  in_valid_i       = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            char_code_i      = 8'h00;
  logic                  last_i           = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i      = 1'b0;
  logic [7:0]            data_byte_o;
  logic                  byte_valid_o;
  logic                  end_of_message_o;
  logic                  cfg_valid_i      = 1'b0;
  logic                  cfg_ready_o;
  logic [LimitWidth-1:0] cfg_data_i       = '0;

  int   fail_count;
  int   awaited;
  int   items_sent   = 0;
  int   stall_cycles = 0;
  logic calm         = 1'b0;

  base64_stream_decoder_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_code_i      (char_code_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .data_byte_o      (data_byte_o),
    .byte_valid_o     (byte_valid_o),
    .end_of_message_o (end_of_message_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  base64_decode_checker decode_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_code_i      (char_code_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .data_byte_o      (data_byte_o),
    .byte_valid_o     (byte_valid_o),
    .end_of_message_o (end_of_message_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .awaited_o        (awaited)
  );

  // Free-running clock.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // The receiver stalls now and then, except during the calm phase.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 20);
  end

  // Watchdog: ends the run when no request moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WatchdogLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Maps 0..63 onto a character of the alphabet.
  function automatic logic [7:0] alphabet_char(input int idx);
    if (idx < 26) return 8'(CharUpperA + idx);
    if (idx < 52) return 8'(CharLowerA + idx - 26);
    if (idx < 62) return 8'(CharDigit0 + idx - 52);
    if (idx == 62) return CharPlus;
    return CharSlash;
  endfunction

  function automatic logic [7:0] random_alpha();
    return alphabet_char($urandom_range(0, 63));
  endfunction

  // Presents one character and holds it until accepted; valid stays high afterwards.
  task automatic send_char(input logic [7:0] c, input logic fin);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    last_i      <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Sends a string, marking its final character as last when asked.
  task automatic send_text(input string s, input logic fin);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], fin && (i == s.len() - 1));
  endtask

  // Stops sending until every expected result has been delivered.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited != 0);
  endtask

  // Writes the byte limit; only called while the decoder is idle.
  task automatic write_limit(input logic [LimitWidth-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // One random message: mostly well formed, some noise, some broken groups.
  task automatic send_message();
    logic [7:0] msg[$];
    int         kind;
    int         ngroups;
    int         tail;
    int         i;
    logic       fin;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      ngroups = $urandom_range(0, 3);
      repeat (ngroups * 4) msg = {msg, random_alpha()};
      tail = $urandom_range((ngroups == 0) ? 1 : 0, 5);
      case (tail)
        1: begin
          repeat (2) msg = {msg, random_alpha()};
          repeat (2) msg = {msg, 8'("=")};
        end
        2: begin
          repeat (3) msg = {msg, random_alpha()};
          msg = {msg, 8'("=")};
        end
        3: repeat (2) msg = {msg, random_alpha()};
        4: repeat (3) msg = {msg, random_alpha()};
        5: msg = {msg, random_alpha()};
        default: ;
      endcase
    end else if (kind <= 8) begin
      repeat ($urandom_range(1, 10)) msg = {msg, 8'($urandom_range(0, 255))};
    end else begin
      repeat ($urandom_range(1, 9)) begin
        msg = {msg, (($urandom_range(0, 4) == 0) ? 8'("=") : random_alpha())};
      end
    end
    for (i = 0; i < msg.size(); i++) begin
      // A rare stray character shifts the group alignment of well-formed input.
      if (kind <= 6 && $urandom_range(0, 29) == 0) send_char(8'($urandom_range(0, 255)), 1'b0);
      if ($urandom_range(0, 199) == 0) wait_drained();
      fin = (i == msg.size() - 1) || (kind >= 7 && $urandom_range(0, 9) == 0);
      send_char(msg[i], fin);
    end
  endtask

  // Main sequence: reset, directed characters, then random phases under several limits.
  initial begin : stimulus
    logic [LimitWidth-1:0] phase_limit[6];
    int                    target;
    int                    p;
    phase_limit = '{24'd1, 24'd2, 24'd7, 24'hFFFFFF, 24'd0, 24'd0};
    phase_limit[4] = LimitWidth'($urandom_range(3, 40));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_limit('0);

    // Full groups over the alphabet edges, padded and short endings.
    send_text("TWFu", 1'b0);
    send_text("AZaz", 1'b0);
    send_text("09+/", 1'b0);
    send_text("TW==", 1'b1);
    send_text("QUI", 1'b1);
    send_text("Q", 1'b1);
    // Characters outside the alphabet only take positions.
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b0);
    send_char("=", 1'b0);
    send_char("A", 1'b1);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    for (p = 0; p < 6; p++) begin
      calm = (p == 3);
      write_limit(phase_limit[p]);
      target = items_sent + PhaseItems;
      while (items_sent < target) send_message();
      wait_drained();
      repeat (SettleCycles) @(posedge clk_i);
    end
    calm = 1'b0;

    if (fail_count == 0 && awaited == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
